// File: sv/slcc_pkg.sv
// Shared constants, types and ring order for the superpixel connectivity check.
`timescale 1ns / 1ps
package slcc_pkg;

    localparam int LABEL_BITS_DEF = 16;
    localparam int NBR_COUNT      = 8;
    localparam int NBR_IDX_BITS   = $clog2(NBR_COUNT);

    typedef logic [NBR_COUNT-1:0] nbr_mask_t;

    localparam nbr_mask_t MASK_FULL = '1;

    // Mask bit of each neighbour walking the 4-adjacency ring clockwise from UL.
    localparam logic [NBR_IDX_BITS-1:0] RING_POS [NBR_COUNT] =
        '{3'd0, 3'd1, 3'd2, 3'd4, 3'd7, 3'd6, 3'd5, 3'd3};

    // Pipeline control handed from the window stage to the result stage.
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctrl_t;

endpackage

// File: sv/slcc_if.sv
// Channel interfaces: label window in, connectivity result out.
`timescale 1ns / 1ps
interface slcc_win_if
    import slcc_pkg::*;
#(
    parameter int LABEL_BITS = LABEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [LABEL_BITS-1:0] centre_label;
    logic [LABEL_BITS-1:0] label_up_left;
    logic [LABEL_BITS-1:0] label_up;
    logic [LABEL_BITS-1:0] label_up_right;
    logic [LABEL_BITS-1:0] label_left;
    logic [LABEL_BITS-1:0] label_right;
    logic [LABEL_BITS-1:0] label_down_left;
    logic [LABEL_BITS-1:0] label_down;
    logic [LABEL_BITS-1:0] label_down_right;
    logic [NBR_COUNT-1:0]  inside_mask;

    modport source (
        output valid, centre_label, label_up_left, label_up, label_up_right,
               label_left, label_right, label_down_left, label_down,
               label_down_right, inside_mask,
        input  ready
    );
    modport sink (
        input  valid, centre_label, label_up_left, label_up, label_up_right,
               label_left, label_right, label_down_left, label_down,
               label_down_right, inside_mask,
        output ready
    );
endinterface

interface slcc_res_if
    import slcc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 stays_connected;
    logic [NBR_COUNT-1:0] same_label_mask;

    modport source (
        output valid, stays_connected, same_label_mask,
        input  ready
    );
    modport sink (
        input  valid, stays_connected, same_label_mask,
        output ready
    );
endinterface

// File: sv/slcc_match.sv
// Label comparator: marks in-image neighbours that share the centre's label.
`timescale 1ns / 1ps
module slcc_match
    import slcc_pkg::*;
#(
    parameter int LABEL_BITS = LABEL_BITS_DEF
)(
    input  logic [LABEL_BITS-1:0]                centre,
    input  logic [NBR_COUNT-1:0][LABEL_BITS-1:0] nbr,
    input  nbr_mask_t                            in_img,
    output nbr_mask_t                            same
);

    always_comb
    begin
        for (int i = 0; i < NBR_COUNT; i++)
        begin
            same[i] = in_img[i] && (nbr[i] == centre);
        end
    end

endmodule

// File: sv/slcc_ring.sv
// Ring run detector: one 4-connected component among the eight neighbours.
`timescale 1ns / 1ps
module slcc_ring
    import slcc_pkg::*;
(
    input  nbr_mask_t mask,
    output logic      connected
);

    nbr_mask_t ring;
    nbr_mask_t prev;
    nbr_mask_t starts;

    always_comb
    begin
        for (int k = 0; k < NBR_COUNT; k++)
        begin
            ring[k] = mask[RING_POS[k]];
        end
    end

    // prev[k] is the ring neighbour just before position k
    assign prev   = {ring[NBR_COUNT-2:0], ring[NBR_COUNT-1]};
    assign starts = ring & ~prev;

    // exactly one run start, or the full ring (which has none)
    assign connected = (mask == MASK_FULL) ||
                       ((starts != '0) && ((starts & (starts - nbr_mask_t'(1))) == '0));

endmodule

// File: sv/superpixel_local_connectivity_check.sv
// Top level: window register, label compare and ring test, result register.
//
// Usage:
//   win carries one 3x3 label window per beat: the centre label, its eight
//   neighbour labels and inside_mask (bit 0 UL .. bit 7 DR, raster order
//   without the centre). res returns one beat per window: same_label_mask,
//   the in-image neighbours with the centre's label, and stays_connected,
//   set when those positions form one 4-connected run around the ring.
//   Labels are compared over LABEL_BITS bits.
//   Each accepted window passes the window register, then the result
//   register; the compare and ring test sit between them, so one window
//   is taken every cycle while res.ready stays high.
//   When the receiver stalls, the result register holds its beat; the window
//   register still takes one more window, then win.ready drops until the
//   result is taken. Order is kept, nothing is dropped or repeated.
//   Reset empties both registers; the block holds no other state.
`timescale 1ns / 1ps
module superpixel_local_connectivity_check
    import slcc_pkg::*;
#(
    parameter int LABEL_BITS = LABEL_BITS_DEF
)(
    input  logic           clk,
    input  logic           rst_n,
    slcc_win_if.sink       win,
    slcc_res_if.source     res
);

    logic                                  win_valid_reg;
    logic [LABEL_BITS-1:0]                 centre_reg;
    logic [NBR_COUNT-1:0][LABEL_BITS-1:0]  nbr_reg;
    nbr_mask_t                             inside_reg;

    logic                                  res_valid_reg;
    logic                                  conn_reg;
    nbr_mask_t                             mask_reg;

    stage_ctrl_t                           win_ctrl;
    nbr_mask_t                             same_mask;
    logic                                  connected;
    logic                                  win_take;

    assign win_ctrl.valid   = win_valid_reg;
    assign win_ctrl.advance = win_valid_reg && (!res_valid_reg || res.ready);

    assign win.ready = !win_valid_reg || win_ctrl.advance;
    assign win_take  = win.valid && win.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
        end
        else if (win.ready)
        begin
            win_valid_reg <= win.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_take)
        begin
            centre_reg <= win.centre_label;
            nbr_reg    <= {win.label_down_right, win.label_down, win.label_down_left,
                           win.label_right, win.label_left, win.label_up_right,
                           win.label_up, win.label_up_left};
            inside_reg <= win.inside_mask;
        end
    end

    slcc_match #(
        .LABEL_BITS (LABEL_BITS)
    ) u_match (
        .centre (centre_reg),
        .nbr    (nbr_reg),
        .in_img (inside_reg),
        .same   (same_mask)
    );

    slcc_ring u_ring (
        .mask      (same_mask),
        .connected (connected)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || res.ready)
        begin
            res_valid_reg <= win_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_ctrl.advance)
        begin
            conn_reg <= connected;
            mask_reg <= same_mask;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.stays_connected = conn_reg;
    assign res.same_label_mask = mask_reg;

    // an empty mask is never reported connected
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.stays_connected && (res.same_label_mask == '0)))
        else $error("connected result with empty mask");

    // the full ring is one component
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.same_label_mask == MASK_FULL)) |-> res.stays_connected)
        else $error("full ring not reported connected");

    // a result only marks neighbours that were inside the image
    assert property (@(posedge clk) disable iff (!rst_n)
        win_ctrl.advance |=> ((res.same_label_mask & ~$past(inside_reg)) == '0))
        else $error("mask bit outside the image");

    // a stalled result with a full window register blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid_reg && res_valid_reg && !res.ready) |-> !win.ready)
        else $error("window taken while both stages are blocked");

    // a window held in the window register moves on exactly when the result slot frees
    assert property (@(posedge clk) disable iff (!rst_n)
        (win_ctrl.advance && !win_take) |=> (res_valid_reg && !win_valid_reg))
        else $error("window lost between stages");

endmodule
